>>> hw/rtl/dtpq_pkg.sv
// Package with the shared types and constants of the directed tree path query block.
package dtpq_pkg;

   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 11;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int LVI       = $clog2(LEVELS);
   localparam int LV_W      = $clog2(LEVELS + 1);
   localparam int DEP_W     = 10;
   localparam int CNT_W     = 11;
   localparam int DIR_W     = 2;
   localparam int TBL_DEPTH = LEVELS * MAX_NODES;
   localparam int TBL_AW    = LVI + NODE_W;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_DOWN  = 2'd0,
      DIR_UP    = 2'd1,
      DIR_MIXED = 2'd2
   } dir_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] parent;
      logic              upward;
      logic [NODE_W-1:0] target;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       reachable;
      logic       load_error;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0] anc;
      logic [DIR_W-1:0]  dir;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LD_W,
      S_Q_DA,
      S_Q_DB,
      S_Q_LIFT,
      S_Q_LW,
      S_Q_RA,
      S_Q_RB,
      S_Q_CMP,
      S_B_RA,
      S_B_RB,
      S_B_W,
      S_OUT
   } state_type;

endpackage

>>> hw/rtl/directed_tree_path_query.sv
// Top level of the directed tree path query block.
// A load reads the parent's depth and then writes the node's depth and parent
// entry (a root load writes at once, a rejected parent writes nothing), a build
// composes one entry for every covered node at each of the ten upper levels, and
// a query makes two depth reads, climbs the set bits of the depth gap level by
// level, reads the entries of both nodes at each level on the way down, and ends
// with a final parent step. Builds and queries are paced by the single read port
// of the ancestor memory, which every step of a walk waits on.
// A finished result sits in an output register, and the next transaction is
// taken while it waits. The memories need no clearing after reset.
module directed_tree_path_query (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dtpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtpq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [dtpq_pkg::CNT_W-1:0] csr_data
);

   dtpq_pkg::state_type state_ff, state_in;
   logic [1:0]                    cmd_ff, cmd_in;
   logic [dtpq_pkg::NODE_W-1:0]   a_ff, a_in, b_ff, b_in, par_ff, par_in, k_ff, k_in;
   logic                          up_ff, up_in;
   logic [dtpq_pkg::LV_W-1:0]     lv_ff, lv_in;
   logic [dtpq_pkg::LEVELS-1:0]   gap_ff, gap_in;
   logic                          lift_a_ff, lift_a_in, fin_ff, fin_in;
   logic [dtpq_pkg::DEP_W-1:0]    da_ff, da_in;
   dtpq_pkg::entry_type           e0_ff, e0_in;
   logic                          reach_ff, reach_in, err_ff, err_in;
   logic [dtpq_pkg::CNT_W-1:0]    count_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   dtpq_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          tbl_we;
   logic [dtpq_pkg::TBL_AW-1:0]   tbl_waddr, tbl_raddr;
   dtpq_pkg::entry_type           tbl_wdata, tbl_rd;
   logic                          dep_we;
   logic [dtpq_pkg::NODE_W-1:0]   dep_waddr, dep_raddr;
   logic [dtpq_pkg::DEP_W-1:0]    dep_wdata, dep_rd;

   logic [dtpq_pkg::CNT_W-1:0]    cnt_eff;
   logic [dtpq_pkg::LV_W-1:0]     lv_m1;
   logic [dtpq_pkg::NODE_W-1:0]   lift_p;
   logic [dtpq_pkg::DIR_W-1:0]    need;
   logic                          req_acc, out_free;

   dtpq_ram #(
      .WIDTH($bits(dtpq_pkg::entry_type)),
      .DEPTH(dtpq_pkg::TBL_DEPTH)
   ) u_tbl (
      .clock(clock), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
      .raddr(tbl_raddr), .rdata(tbl_rd)
   );

   dtpq_ram #(
      .WIDTH(dtpq_pkg::DEP_W),
      .DEPTH(dtpq_pkg::MAX_NODES)
   ) u_dep (
      .clock(clock), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
      .raddr(dep_raddr), .rdata(dep_rd)
   );

   // Configuration register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= dtpq_pkg::CNT_W'(dtpq_pkg::MAX_NODES);
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   assign cnt_eff  = (count_ff > dtpq_pkg::CNT_W'(dtpq_pkg::MAX_NODES)) ?
                     dtpq_pkg::CNT_W'(dtpq_pkg::MAX_NODES) : count_ff;
   assign lv_m1    = lv_ff - 1'b1;
   assign lift_p   = lift_a_ff ? a_ff : b_ff;
   assign need     = lift_a_ff ? dtpq_pkg::DIR_UP : dtpq_pkg::DIR_DOWN;
   assign req_ready = (state_ff == dtpq_pkg::S_IDLE);
   assign req_acc  = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtpq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      par_ff    <= par_in;
      up_ff     <= up_in;
      k_ff      <= k_in;
      lv_ff     <= lv_in;
      gap_ff    <= gap_in;
      lift_a_ff <= lift_a_in;
      fin_ff    <= fin_in;
      da_ff     <= da_in;
      e0_ff     <= e0_in;
      reach_ff  <= reach_in;
      err_ff    <= err_in;
      rsp_ff    <= rsp_in;
   end

   // Sequencer: next state, memory accesses and result.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      par_in       = par_ff;
      up_in        = up_ff;
      k_in         = k_ff;
      lv_in        = lv_ff;
      gap_in       = gap_ff;
      lift_a_in    = lift_a_ff;
      fin_in       = fin_ff;
      da_in        = da_ff;
      e0_in        = e0_ff;
      reach_in     = reach_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tbl_we       = 1'b0;
      tbl_waddr    = {lv_ff[dtpq_pkg::LVI-1:0], k_ff};
      tbl_wdata    = e0_ff;
      tbl_raddr    = {lv_ff[dtpq_pkg::LVI-1:0], a_ff};
      dep_we       = 1'b0;
      dep_waddr    = a_ff;
      dep_wdata    = dep_rd + 1'b1;
      dep_raddr    = req_data.parent;
      unique case (state_ff)
         dtpq_pkg::S_IDLE: begin
            if (req_acc) begin
               cmd_in   = req_data.cmd;
               a_in     = req_data.node;
               b_in     = req_data.target;
               par_in   = req_data.parent;
               up_in    = req_data.upward;
               reach_in = 1'b0;
               err_in   = 1'b0;
               fin_in   = 1'b0;
               case (req_data.cmd)
                  dtpq_pkg::CMD_LOAD: begin
                     if (req_data.node == '0) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = '0;
                        tbl_wdata = '{anc: '0, dir: dtpq_pkg::DIR_DOWN};
                        dep_we    = 1'b1;
                        dep_waddr = '0;
                        dep_wdata = '0;
                        state_in  = dtpq_pkg::S_OUT;
                     end else if (req_data.parent >= req_data.node) begin
                        err_in   = 1'b1;
                        state_in = dtpq_pkg::S_OUT;
                     end else begin
                        dep_raddr = req_data.parent;
                        state_in  = dtpq_pkg::S_LD_W;
                     end
                  end
                  dtpq_pkg::CMD_BUILD: begin
                     lv_in    = dtpq_pkg::LV_W'(1);
                     k_in     = '0;
                     state_in = (cnt_eff == '0) ? dtpq_pkg::S_OUT : dtpq_pkg::S_B_RA;
                  end
                  dtpq_pkg::CMD_QUERY: begin
                     if (req_data.node == req_data.target) begin
                        reach_in = 1'b1;
                        state_in = dtpq_pkg::S_OUT;
                     end else begin
                        dep_raddr = req_data.node;
                        state_in  = dtpq_pkg::S_Q_DA;
                     end
                  end
                  default: begin
                     state_in = dtpq_pkg::S_IDLE;
                  end
               endcase
            end
         end
         dtpq_pkg::S_LD_W: begin
            dep_we    = 1'b1;
            dep_waddr = a_ff;
            dep_wdata = dep_rd + 1'b1;
            tbl_we    = 1'b1;
            tbl_waddr = {{dtpq_pkg::LVI{1'b0}}, a_ff};
            tbl_wdata = '{anc: par_ff, dir: {1'b0, up_ff}};
            state_in  = dtpq_pkg::S_OUT;
         end
         dtpq_pkg::S_Q_DA: begin
            da_in     = dep_rd;
            dep_raddr = b_ff;
            state_in  = dtpq_pkg::S_Q_DB;
         end
         dtpq_pkg::S_Q_DB: begin
            if (da_ff > dep_rd) begin
               gap_in    = dtpq_pkg::LEVELS'(da_ff - dep_rd);
               lift_a_in = 1'b1;
            end else begin
               gap_in    = dtpq_pkg::LEVELS'(dep_rd - da_ff);
               lift_a_in = 1'b0;
            end
            lv_in    = '0;
            state_in = dtpq_pkg::S_Q_LIFT;
         end
         dtpq_pkg::S_Q_LIFT: begin
            // Climb one set bit of the depth gap at a time.
            tbl_raddr = {lv_ff[dtpq_pkg::LVI-1:0], lift_p};
            if (lv_ff == dtpq_pkg::LV_W'(dtpq_pkg::LEVELS)) begin
               if (a_ff == b_ff) begin
                  reach_in = 1'b1;
                  state_in = dtpq_pkg::S_OUT;
               end else begin
                  lv_in    = dtpq_pkg::LV_W'(dtpq_pkg::LEVELS - 1);
                  state_in = dtpq_pkg::S_Q_RA;
               end
            end else if (gap_ff[lv_ff[dtpq_pkg::LVI-1:0]]) begin
               state_in = dtpq_pkg::S_Q_LW;
            end else begin
               lv_in = lv_ff + 1'b1;
            end
         end
         dtpq_pkg::S_Q_LW: begin
            if (tbl_rd.dir != need) begin
               state_in = dtpq_pkg::S_OUT;
            end else begin
               if (lift_a_ff) begin
                  a_in = tbl_rd.anc;
               end else begin
                  b_in = tbl_rd.anc;
               end
               lv_in    = lv_ff + 1'b1;
               state_in = dtpq_pkg::S_Q_LIFT;
            end
         end
         dtpq_pkg::S_Q_RA: begin
            tbl_raddr = {lv_ff[dtpq_pkg::LVI-1:0], a_ff};
            state_in  = dtpq_pkg::S_Q_RB;
         end
         dtpq_pkg::S_Q_RB: begin
            e0_in     = tbl_rd;
            tbl_raddr = {lv_ff[dtpq_pkg::LVI-1:0], b_ff};
            state_in  = dtpq_pkg::S_Q_CMP;
         end
         dtpq_pkg::S_Q_CMP: begin
            // Joint descent, then the final parent step with fin set.
            if (fin_ff) begin
               reach_in = (e0_ff.anc == tbl_rd.anc) && (e0_ff.dir == dtpq_pkg::DIR_UP)
                          && (tbl_rd.dir == dtpq_pkg::DIR_DOWN);
               state_in = dtpq_pkg::S_OUT;
            end else if ((e0_ff.anc != tbl_rd.anc) && ((e0_ff.dir != dtpq_pkg::DIR_UP)
                         || (tbl_rd.dir != dtpq_pkg::DIR_DOWN))) begin
               state_in = dtpq_pkg::S_OUT;
            end else begin
               if (e0_ff.anc != tbl_rd.anc) begin
                  a_in = e0_ff.anc;
                  b_in = tbl_rd.anc;
               end
               if (lv_ff == '0) begin
                  fin_in = 1'b1;
               end else begin
                  lv_in = lv_ff - 1'b1;
               end
               state_in = dtpq_pkg::S_Q_RA;
            end
         end
         dtpq_pkg::S_B_RA: begin
            tbl_raddr = {lv_m1[dtpq_pkg::LVI-1:0], k_ff};
            state_in  = dtpq_pkg::S_B_RB;
         end
         dtpq_pkg::S_B_RB: begin
            e0_in     = tbl_rd;
            tbl_raddr = {lv_m1[dtpq_pkg::LVI-1:0], tbl_rd.anc};
            state_in  = dtpq_pkg::S_B_W;
         end
         dtpq_pkg::S_B_W: begin
            // Compose two half runs into one entry of the next level.
            tbl_we    = 1'b1;
            tbl_waddr = {lv_ff[dtpq_pkg::LVI-1:0], k_ff};
            tbl_wdata = '{anc: tbl_rd.anc,
                          dir: (e0_ff.dir == tbl_rd.dir) ? e0_ff.dir : dtpq_pkg::DIR_MIXED};
            if ({1'b0, k_ff} == cnt_eff - 1'b1) begin
               k_in = '0;
               if (lv_ff == dtpq_pkg::LV_W'(dtpq_pkg::LEVELS - 1)) begin
                  state_in = dtpq_pkg::S_OUT;
               end else begin
                  lv_in    = lv_ff + 1'b1;
                  state_in = dtpq_pkg::S_B_RA;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = dtpq_pkg::S_B_RA;
            end
         end
         dtpq_pkg::S_OUT: begin
            if (out_free) begin
               rsp_in       = '{kind: cmd_ff, reachable: reach_ff, load_error: err_ff};
               rsp_valid_in = 1'b1;
               state_in     = dtpq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dtpq_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // The ancestor memory is never written while a query walks it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtpq_pkg::S_Q_LIFT || state_ff == dtpq_pkg::S_Q_LW ||
       state_ff == dtpq_pkg::S_Q_RA || state_ff == dtpq_pkg::S_Q_RB ||
       state_ff == dtpq_pkg::S_Q_CMP) |-> !tbl_we)
      else $error("ancestor memory written during a query");

   // Depths are written only by loads.
   assert property (@(posedge clock) disable iff (reset)
      dep_we |-> (state_ff == dtpq_pkg::S_IDLE || state_ff == dtpq_pkg::S_LD_W))
      else $error("depth memory written outside a load");

   // Only a load result may flag an error, and only a query may be reachable.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.kind == dtpq_pkg::CMD_LOAD) || !rsp_ff.load_error) &&
                       ((rsp_ff.kind == dtpq_pkg::CMD_QUERY) || !rsp_ff.reachable))
      else $error("result flags do not match its kind");

   // A result is produced only when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtpq_pkg::S_OUT && !out_free) |=> (state_ff == dtpq_pkg::S_OUT))
      else $error("result left before the output register was free");
`endif

endmodule

>>> hw/rtl/dtpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dtpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
